// ===== sv/sidx_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment index box parser package
// Shared types, codes and constants for the segment index box parser.
// ----------------------------------------------------------------------------
package sidx_pkg;

  localparam int unsigned HEAD_SIZE  = 8;
  localparam int unsigned OUTQ_DEPTH = 8;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam logic [31:0] SIDX_TYPE = 32'h7369_6478;

  // Configuration register indexes.
  localparam logic CFG_STREAM_BYTES    = 1'b0;
  localparam logic CFG_SIDX_END_OFFSET = 1'b1;

  typedef enum logic [3:0] {
    PH_SIZE   = 4'd0,
    PH_TYPE   = 4'd1,
    PH_VFLAG  = 4'd2,
    PH_REFID  = 4'd3,
    PH_TSCALE = 4'd4,
    PH_EPT    = 4'd5,
    PH_FOFF   = 4'd6,
    PH_RSV    = 4'd7,
    PH_RCNT   = 4'd8,
    PH_RTS    = 4'd9,
    PH_RDUR   = 4'd10,
    PH_RSAP   = 4'd11
  } sidx_phase_e;

  typedef enum logic [1:0] {
    KIND_ENTRY    = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_BAD_TYPE = 2'd2,
    KIND_TRUNC    = 2'd3
  } sidx_kind_e;

  typedef struct packed {
    logic [31:0] pos;
    sidx_phase_e phase;
    logic [2:0]  cnt;
    logic [63:0] acc;
    logic        ver_nz;
    logic [31:0] tscale;
    logic [63:0] run_off;
    logic [15:0] refs_left;
    logic [31:0] type_size;
    logic [31:0] dur;
    logic        halted;
  } sidx_state_t;

  typedef struct packed {
    sidx_kind_e  kind;
    logic        ref_type;
    logic [30:0] ref_size;
    logic [63:0] start_pos;
    logic [63:0] end_pos;
    logic [31:0] duration;
    logic [31:0] time_scale;
    logic        last;
  } sidx_result_t;

endpackage

// ===== sv/sidx_step.sv =====
// ----------------------------------------------------------------------------
// Segment index box parser byte step
// Combinational update of the field state for one stream byte, producing up
// to two results (an entry and a status).
// ----------------------------------------------------------------------------
module sidx_step (
  input  sidx_pkg::sidx_state_t  state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   first_byte_i,
  input  logic [31:0]            stream_bytes_i,
  input  logic [47:0]            sidx_end_offset_i,
  output sidx_pkg::sidx_state_t  state_o,
  output sidx_pkg::sidx_result_t res_o [2],
  output logic [1:0]             n_res_o
);
  import sidx_pkg::*;

  function automatic logic may_start(logic [31:0] p, logic [31:0] sb);
    logic [31:0] left;
    left = sb - p;
    return (p < sb) && (left > 32'(HEAD_SIZE));
  endfunction

  sidx_state_t  base;
  sidx_state_t  nxt;
  sidx_result_t stat_res;
  sidx_result_t ent_res;
  logic         ent;
  logic         stat;
  logic         box_done;
  logic         bad_type;
  logic [63:0]  acc_new;
  logic [31:0]  pos_new;
  logic [3:0]   flen;
  logic [63:0]  size64;

  always_comb begin
    base = first_byte_i ? '0 : state_i;
    nxt      = base;
    ent      = 1'b0;
    stat     = 1'b0;
    box_done = 1'b0;
    bad_type = 1'b0;
    stat_res = '0;
    ent_res  = '0;
    acc_new  = {base.acc[55:0], data_byte_i};
    pos_new  = base.pos + 32'd1;
    size64   = {33'd0, base.type_size[30:0]};

    case (base.phase)
      PH_EPT, PH_FOFF: flen = base.ver_nz ? 4'd8 : 4'd4;
      PH_RSV, PH_RCNT: flen = 4'd2;
      default:         flen = 4'd4;
    endcase

    if (!base.halted) begin
      if (base.phase == PH_SIZE && base.cnt == 3'd0 && !may_start(base.pos, stream_bytes_i)) begin
        // Not enough bytes left for another box header: this byte is dropped.
        stat          = 1'b1;
        stat_res.kind = KIND_DONE;
        nxt.halted    = 1'b1;
      end else begin
        nxt.acc = acc_new;
        nxt.pos = pos_new;
        if ({1'b0, base.cnt} + 4'd1 < flen) begin
          nxt.cnt = base.cnt + 3'd1;
        end else begin
          nxt.cnt = 3'd0;
          nxt.acc = '0;
          case (base.phase)
            PH_SIZE: nxt.phase = PH_TYPE;
            PH_TYPE: begin
              if (acc_new[31:0] != SIDX_TYPE) begin
                bad_type      = 1'b1;
                stat          = 1'b1;
                stat_res.kind = KIND_BAD_TYPE;
                nxt.halted    = 1'b1;
              end else begin
                nxt.phase = PH_VFLAG;
              end
            end
            PH_VFLAG: begin
              nxt.ver_nz = acc_new[31:24] != 8'd0;
              nxt.phase  = PH_REFID;
            end
            PH_REFID: nxt.phase = PH_TSCALE;
            PH_TSCALE: begin
              nxt.tscale = acc_new[31:0];
              nxt.phase  = PH_EPT;
            end
            PH_EPT: nxt.phase = PH_FOFF;
            PH_FOFF: begin
              nxt.run_off = acc_new + {16'd0, sidx_end_offset_i} + 64'd1;
              nxt.phase   = PH_RSV;
            end
            PH_RSV: nxt.phase = PH_RCNT;
            PH_RCNT: begin
              nxt.refs_left = acc_new[15:0];
              if (acc_new[15:0] == 16'd0) begin
                box_done = 1'b1;
              end else begin
                nxt.phase = PH_RTS;
              end
            end
            PH_RTS: begin
              nxt.type_size = acc_new[31:0];
              nxt.phase     = PH_RDUR;
            end
            PH_RDUR: begin
              nxt.dur   = acc_new[31:0];
              nxt.phase = PH_RSAP;
            end
            PH_RSAP: begin
              ent                = 1'b1;
              ent_res.kind       = KIND_ENTRY;
              ent_res.ref_type   = base.type_size[31];
              ent_res.ref_size   = base.type_size[30:0];
              ent_res.start_pos  = base.run_off;
              ent_res.end_pos    = base.run_off + size64 - 64'd1;
              ent_res.duration   = base.dur;
              ent_res.time_scale = base.tscale;
              nxt.run_off        = base.run_off + size64;
              nxt.refs_left      = base.refs_left - 16'd1;
              if (base.refs_left == 16'd1) begin
                box_done = 1'b1;
              end else begin
                nxt.phase = PH_RTS;
              end
            end
            default: nxt.phase = PH_SIZE;
          endcase
        end

        if (!bad_type) begin
          if (box_done) begin
            nxt.phase = PH_SIZE;
            nxt.cnt   = 3'd0;
            if (!may_start(pos_new, stream_bytes_i)) begin
              stat          = 1'b1;
              stat_res.kind = KIND_DONE;
              nxt.halted    = 1'b1;
            end
          end else if (pos_new >= stream_bytes_i) begin
            stat          = 1'b1;
            stat_res.kind = KIND_TRUNC;
            nxt.halted    = 1'b1;
          end
        end
      end
    end

    if (stat) begin
      stat_res.last = 1'b1;
    end else begin
      ent_res.last = 1'b1;
    end
  end

  // The entry, when present, always goes out ahead of the status result.
  assign res_o[0] = ent ? ent_res : stat_res;
  assign res_o[1] = stat_res;
  assign n_res_o  = {1'b0, ent} + {1'b0, stat};
  assign state_o  = nxt;

endmodule

// ===== sv/sidx_outq.sv =====
// ----------------------------------------------------------------------------
// Segment index box parser result queue
// Small queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module sidx_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             push_cnt_i,
  input  sidx_pkg::sidx_result_t push_data_i [2],
  input  logic                   pop_i,
  output sidx_pkg::sidx_result_t data_o,
  output logic                   valid_o,
  output logic [sidx_pkg::OUTQ_AW:0] count_o
);
  import sidx_pkg::*;

  sidx_result_t       mem_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wptr_q, wptr_d;
  logic [OUTQ_AW-1:0] rptr_q, rptr_d;
  logic [OUTQ_AW:0]   count_q, count_d;
  logic [OUTQ_AW-1:0] wptr_p1;
  logic               pop;

  assign pop     = pop_i && (count_q != '0);
  assign wptr_p1 = wptr_q + OUTQ_AW'(1);

  always_comb begin
    wptr_d  = wptr_q + OUTQ_AW'(push_cnt_i);
    rptr_d  = pop ? rptr_q + OUTQ_AW'(1) : rptr_q;
    count_d = count_q + (OUTQ_AW + 1)'(push_cnt_i) - (OUTQ_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= push_data_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wptr_p1] <= push_data_i[1];
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign valid_o = count_q != '0;
  assign count_o = count_q;

endmodule

// ===== sv/segment_index_box_parser_core.sv =====
// ----------------------------------------------------------------------------
// Segment index box parser core
// Parses a byte stream of segment index boxes and emits one result per
// reference entry plus a status result when parsing ends.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tdata: data_byte; tuser: first_byte
//  m_axis   | out       | tdata: entry fields; tuser: kind; tlast: last
//  cfg      | in        | cfg_index_i selects register, cfg_data_i value
//
//  Each byte is registered in the input register, then passes through the step
//  logic into the result queue; a byte can be taken every cycle unless stalled.
//  A byte yields at most two results; the eight-entry result queue sets the
//  stall: s_axis_tready drops when fewer than four entries are free while a
//  byte sits in the input register, and when fewer than two are free otherwise.
//  Reset clears the parser state, the registers and the queue; the parser
//  also restarts on a byte with first_byte set.
// ----------------------------------------------------------------------------
module segment_index_box_parser_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] first_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] reference_type, [31:1] referenced_size, [95:32] start_pos,
  // [159:96] end_pos, [191:160] duration, [223:192] time_scale
  output logic [223:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] kind
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [47:0]  cfg_data_i
);
  import sidx_pkg::*;

  logic [31:0]        stream_bytes_q;
  logic [47:0]        sidx_end_offset_q;
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_first_q;
  sidx_state_t        state_q, state_d;
  sidx_result_t       step_res [2];
  logic [1:0]         n_res;
  logic [1:0]         push_cnt;
  sidx_result_t       head;
  logic [OUTQ_AW:0]   q_count;
  logic [OUTQ_AW+1:0] q_need;
  logic               s_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_bytes_q    <= '0;
      sidx_end_offset_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STREAM_BYTES:    stream_bytes_q    <= cfg_data_i[31:0];
        CFG_SIDX_END_OFFSET: sidx_end_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Room is reserved for two results from the byte in flight and two more
  // from the byte about to be taken.
  assign q_need = {1'b0, q_count} + (in_valid_q ? (OUTQ_AW + 2)'(2) : '0)
                + (OUTQ_AW + 2)'(2);
  assign s_axis_tready = q_need <= (OUTQ_AW + 2)'(OUTQ_DEPTH);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= s_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
  end

  sidx_step u_step (
    .state_i          (state_q),
    .data_byte_i      (in_byte_q),
    .first_byte_i     (in_first_q),
    .stream_bytes_i   (stream_bytes_q),
    .sidx_end_offset_i(sidx_end_offset_q),
    .state_o          (state_d),
    .res_o            (step_res),
    .n_res_o          (n_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_valid_q) begin
      state_q <= state_d;
    end
  end

  assign push_cnt = in_valid_q ? n_res : 2'd0;

  sidx_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push_data_i(step_res),
    .pop_i      (m_axis_tready),
    .data_o     (head),
    .valid_o    (m_axis_tvalid),
    .count_o    (q_count)
  );

  assign m_axis_tdata = {head.time_scale, head.duration, head.end_pos, head.start_pos,
                         head.ref_size, head.ref_type};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // The result queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= (OUTQ_AW + 1)'(OUTQ_DEPTH))
    else $error("result queue overflow");

  // A status result always leaves the parser halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && n_res != 2'd0 && step_res[1].kind != KIND_ENTRY
     && (n_res == 2'd2 || step_res[0].kind != KIND_ENTRY)) |=> state_q.halted)
    else $error("parser not halted after status result");

  // A halted parser stays silent until a restart byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && state_q.halted && !in_first_q) |-> (n_res == 2'd0))
    else $error("result from halted parser");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Segment index box parser testbench
// Streams buffers of segment index boxes into the parser. The buffers are
// directed cases first, then random well-formed, broken and noise buffers.
// Each result is checked against a cycle-free model of the byte parser that
// runs on every accepted input transfer. Both stream sides idle at random
// rates, and one stretch holds the output off while bytes are still offered.
// ----------------------------------------------------------------------------
module tb_top;
  import sidx_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_index_i = 1'b0;
  logic [47:0]  cfg_data_i = '0;

  segment_index_box_parser_core DUT (.*);

  always #5 clk_i = ~clk_i;

  // Model of the parser: registers and state.
  logic [31:0]  cfg_stream_bytes = '0;
  logic [47:0]  cfg_anchor = '0;
  logic [31:0]  pos = '0;
  sidx_phase_e  phase = PH_SIZE;
  int           fcount = 0;
  logic [63:0]  acc = '0;
  logic         wide = 1'b0;
  logic [31:0]  tscale = '0;
  logic [63:0]  next_start = '0;
  logic [15:0]  refs_left = '0;
  logic [31:0]  ref_word = '0;
  logic [31:0]  ref_dur = '0;
  logic         halted = 1'b0;

  sidx_result_t pending_parse_results[$];
  sidx_result_t want;
  int           mismatches = 0;
  int           sent_bytes = 0;
  int           stuck_cycles = 0;
  int           src_idle_pct = 0;
  int           sink_idle_pct = 0;
  logic         sink_hold = 1'b0;

  function automatic void clear_parser();
    pos = '0;
    phase = PH_SIZE;
    fcount = 0;
    acc = '0;
    wide = 1'b0;
    tscale = '0;
    next_start = '0;
    refs_left = '0;
    ref_word = '0;
    ref_dur = '0;
    halted = 1'b0;
  endfunction

  function automatic bit may_start();
    return (pos < cfg_stream_bytes) && (cfg_stream_bytes - pos > HEAD_SIZE);
  endfunction

  // Advances the model by one byte and queues the results it causes.
  // Returns 0 when the byte is dropped because the parser has halted.
  function automatic bit parse_byte(input logic [7:0] b, input logic first);
    sidx_result_t res[$];
    sidx_result_t r;
    logic [63:0]  value;
    int           flen;
    bit           box_done;
    bit           stop;
    box_done = 1'b0;
    stop = 1'b0;
    r = '0;
    if (first) clear_parser();
    if (halted) return 1'b0;
    if (phase == PH_SIZE && fcount == 0 && !may_start()) begin
      r.kind = KIND_DONE;
      res = {res, r};
      halted = 1'b1;
    end else begin
      flen = (phase == PH_EPT || phase == PH_FOFF) ? (wide ? 8 : 4) :
             (phase == PH_RSV || phase == PH_RCNT) ? 2 : 4;
      acc = {acc[55:0], b};
      pos = pos + 32'd1;
      if (fcount + 1 < flen) begin
        fcount++;
      end else begin
        fcount = 0;
        value = acc;
        acc = '0;
        case (phase)
          PH_SIZE: phase = PH_TYPE;
          PH_TYPE: begin
            if (value[31:0] != SIDX_TYPE) begin
              r.kind = KIND_BAD_TYPE;
              res = {res, r};
              halted = 1'b1;
              stop = 1'b1;
            end else begin
              phase = PH_VFLAG;
            end
          end
          PH_VFLAG: begin
            wide = (value[31:24] != 8'd0);
            phase = PH_REFID;
          end
          PH_REFID: phase = PH_TSCALE;
          PH_TSCALE: begin
            tscale = value[31:0];
            phase = PH_EPT;
          end
          PH_EPT: phase = PH_FOFF;
          PH_FOFF: begin
            next_start = value + {16'd0, cfg_anchor} + 64'd1;
            phase = PH_RSV;
          end
          PH_RSV: phase = PH_RCNT;
          PH_RCNT: begin
            refs_left = value[15:0];
            if (refs_left == 16'd0) box_done = 1'b1;
            else phase = PH_RTS;
          end
          PH_RTS: begin
            ref_word = value[31:0];
            phase = PH_RDUR;
          end
          PH_RDUR: begin
            ref_dur = value[31:0];
            phase = PH_RSAP;
          end
          PH_RSAP: begin
            r.kind = KIND_ENTRY;
            r.ref_type = ref_word[31];
            r.ref_size = ref_word[30:0];
            r.start_pos = next_start;
            r.end_pos = next_start + {33'd0, ref_word[30:0]} - 64'd1;
            r.duration = ref_dur;
            r.time_scale = tscale;
            res = {res, r};
            next_start = r.end_pos + 64'd1;
            refs_left = refs_left - 16'd1;
            if (refs_left == 16'd0) box_done = 1'b1;
            else phase = PH_RTS;
          end
          default: phase = PH_SIZE;
        endcase
      end
      if (!stop) begin
        r = '0;
        if (box_done) begin
          phase = PH_SIZE;
          fcount = 0;
          if (!may_start()) begin
            r.kind = KIND_DONE;
            res = {res, r};
            halted = 1'b1;
          end
        end else if (pos >= cfg_stream_bytes) begin
          r.kind = KIND_TRUNC;
          res = {res, r};
          halted = 1'b1;
        end
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_parse_results = {pending_parse_results, res[i]};
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] expv,
                                      input logic [63:0] actv);
    if (expv !== actv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      mismatches++;
    end
  endfunction

  // Output side: ready at random, forced low during a hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_parse_results.size() == 0) begin
        $error("result transfer with nothing pending, kind %0d", m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_parse_results.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("reference_type", want.ref_type, m_axis_tdata[0]);
        check_field("referenced_size", want.ref_size, m_axis_tdata[31:1]);
        check_field("start_pos", want.start_pos, m_axis_tdata[95:32]);
        check_field("end_pos", want.end_pos, m_axis_tdata[159:96]);
        check_field("duration", want.duration, m_axis_tdata[191:160]);
        check_field("time_scale", want.time_scale, m_axis_tdata[223:192]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick64();
    return {pick32(), pick32()};
  endfunction

  function automatic logic [47:0] pick_anchor();
    case ($urandom_range(3))
      0: return 48'h0;
      1: return {48{1'b1}};
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic void append_word(ref logic [7:0] q[$], input logic [63:0] v,
                                      input int n);
    for (int i = n - 1; i >= 0; i--) q = {q, v[8*i +: 8]};
  endfunction

  // One box; at most four references are laid down whatever the count says.
  // The first reference takes the given words, the rest are random.
  function automatic void append_box(ref logic [7:0] q[$], input logic [31:0] box_type,
                                     input logic [7:0] ver, input logic [31:0] ts,
                                     input logic [63:0] foff, input logic [15:0] rcnt,
                                     input logic [31:0] first_word,
                                     input logic [31:0] first_dur);
    int w;
    int n_refs;
    w = (ver != 8'd0) ? 8 : 4;
    n_refs = (rcnt > 16'd4) ? 4 : int'(rcnt);
    append_word(q, $urandom, 4);
    append_word(q, box_type, 4);
    append_word(q, {ver, 24'($urandom)}, 4);
    append_word(q, $urandom, 4);
    append_word(q, ts, 4);
    append_word(q, pick64(), w);
    append_word(q, foff, w);
    append_word(q, $urandom, 2);
    append_word(q, rcnt, 2);
    for (int i = 0; i < n_refs; i++) begin
      append_word(q, (i == 0) ? first_word : pick32(), 4);
      append_word(q, (i == 0) ? first_dur : pick32(), 4);
      append_word(q, $urandom, 4);
    end
  endfunction

  task automatic wait_idle();
    while (pending_parse_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Both registers in one stretch of cfg_valid_i; the unused top bits of the
  // byte count write carry noise.
  task automatic set_registers(input logic [31:0] len, input logic [47:0] anchor);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_STREAM_BYTES;
    cfg_data_i <= {16'($urandom), len};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_stream_bytes = len;
    cfg_index_i <= CFG_SIDX_END_OFFSET;
    cfg_data_i <= anchor;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_anchor = anchor;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
    void'(parse_byte(b, first));
  endtask

  // A buffer starts with first_byte set; restart_pm adds restarts per mille.
  task automatic send_buffer(input logic [7:0] q[$], input logic [31:0] len,
                             input logic [47:0] anchor, input int restart_pm);
    wait_idle();
    set_registers(len, anchor);
    foreach (q[i]) send_byte(q[i], (i == 0) || ($urandom_range(999) < restart_pm));
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_single_box();
    logic [7:0] q[$];
    append_box(q, SIDX_TYPE, 8'd0, 32'hffff_ffff, 64'd0, 16'd1, 32'hffff_ffff, 32'd0);
    send_buffer(q, q.size(), 48'd0, 0);
  endtask

  // Version 1 with wrapping offsets and a zero-size reference; the stream
  // ends with exactly a header's worth of bytes left, then bytes are ignored.
  task automatic test_wide_fields();
    logic [7:0] q[$];
    append_box(q, SIDX_TYPE, 8'd1, 32'd0, {64{1'b1}}, 16'd2, 32'd0, 32'hffff_ffff);
    send_buffer(q, q.size() + HEAD_SIZE, {48{1'b1}}, 0);
    @(posedge clk_i);
    q = {8'h00, 8'hff, 8'h5a};
    foreach (q[i]) send_byte(q[i], 1'b0);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic test_bad_type();
    logic [7:0] q[$];
    append_box(q, SIDX_TYPE ^ 32'h0100_0000, 8'd0, 32'd1000, 64'd0, 16'd1,
               32'h8000_0001, 32'd1);
    send_buffer(q, 32'hffff_ffff, 48'd0, 0);
  endtask

  // A huge reference count cut off right at the end of the second entry, so
  // the entry and the truncation come from the same byte, then in the fourth.
  task automatic test_truncation();
    logic [7:0] q[$];
    append_box(q, SIDX_TYPE, 8'd0, 32'd90000, 64'd100, 16'hffff, 32'h7fff_ffff, 32'd7);
    send_buffer(q, 32'd56, 48'h1234_5678_9abc, 0);
    send_buffer(q, q.size() - 5, 48'd0, 0);
  endtask

  task automatic test_short_streams();
    logic [7:0] q[$];
    append_box(q, SIDX_TYPE, 8'd0, 32'd48000, 64'd0, 16'd1, 32'd10, 32'd20);
    send_buffer(q, 32'd0, 48'd0, 0);
    send_buffer(q, HEAD_SIZE, 48'd0, 0);
    send_buffer(q, HEAD_SIZE + 1, 48'd0, 0);
  endtask

  // Boxes with zero, two and three references back to back, then a restart in mid box.
  task automatic test_restart();
    logic [7:0] q[$];
    logic [7:0] r[$];
    append_box(q, SIDX_TYPE, 8'd0, 32'd1, 64'd5, 16'd0, 32'd0, 32'd0);
    append_box(q, SIDX_TYPE, 8'd3, 32'd2, 64'd6, 16'd2, 32'd100, 32'd50);
    append_box(q, SIDX_TYPE, 8'd0, 32'd3, 64'd7, 16'd3, 32'd200, 32'd60);
    q = q[0:q.size() - 13];
    send_buffer(q, 32'hffff_ffff, 48'd42, 0);
    append_box(r, SIDX_TYPE, 8'd0, 32'd4, 64'd8, 16'd0, 32'd0, 32'd0);
    send_buffer(r, r.size(), 48'd0, 0);
  endtask

  // The output is held off while the input keeps offering bytes.
  task automatic test_backpressure();
    logic [7:0] q[$];
    repeat (6) append_box(q, SIDX_TYPE, 8'd0, pick32(), pick64(), 16'd4, pick32(), pick32());
    wait_idle();
    sink_hold <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
    join_none
    send_buffer(q, q.size(), pick_anchor(), 0);
  endtask

  task automatic random_buffer();
    logic [7:0]  q[$];
    logic [31:0] len;
    logic [31:0] box_type;
    logic [7:0]  ver;
    int          mode;
    mode = $urandom_range(9);
    if (mode == 8) begin
      repeat ($urandom_range(4, 40)) q = {q, 8'($urandom)};
      send_buffer(q, $urandom_range(0, 48), pick_anchor(), 50);
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      ver = $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 255));
      box_type = (mode == 7 && $urandom_range(1)) ? SIDX_TYPE ^ (32'd1 << $urandom_range(31))
                                                  : SIDX_TYPE;
      append_box(q, box_type, ver, pick32(), pick64(), 16'($urandom_range(0, 4)),
                 pick32(), pick32());
    end
    if (mode == 9) begin
      len = $urandom_range(0, 9);
    end else begin
      case ($urandom_range(5))
        2: len = q.size() + $urandom_range(1, HEAD_SIZE);
        3: len = $urandom_range(1, q.size() - 1);
        4: len = q.size() + $urandom_range(HEAD_SIZE + 1, 40);
        default: len = q.size();
      endcase
    end
    // Trailing bytes are either dropped after a halt or start a bogus box.
    repeat ($urandom_range(0, 12)) q = {q, 8'($urandom)};
    send_buffer(q, len, pick_anchor(), 3);
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n);
    int start_count;
    src_idle_pct <= src_pct;
    sink_idle_pct <= sink_pct;
    start_count = sent_bytes;
    while (sent_bytes - start_count < n) random_buffer();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_box();
    test_wide_fields();
    test_bad_type();
    test_truncation();
    test_short_streams();
    test_restart();
    test_backpressure();
    test_random_traffic(13, 59, 200);
    test_random_traffic(59, 13, 200);
    test_random_traffic(0, 0, 200);
    wait_idle();
    if (mismatches == 0 && pending_parse_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
